// ----- design/mmss_seven_segment_serial_frame_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment serial frame core
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MMSS_SEVEN_SEGMENT_SERIAL_FRAME_CORE_ASSERT_SVH
`define MMSS_SEVEN_SEGMENT_SERIAL_FRAME_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property checked at every rising clock edge outside reset
`define MMSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mmss assertion failed");
// condition that must hold in the cycle after a trigger
`define MMSS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mmss assertion failed");
`else
`define MMSS_ASSERT(label, clk, rst_n, prop)
`define MMSS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- design/mmss_pkg.sv -----
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared types, symbol codes and segment table for the serial frame core.
// ----------------------------------------------------------------------------
`default_nettype none

package mmss_pkg;

    // serial symbol codes
    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_STOP  = 2'd2;

    // request kinds
    localparam logic KIND_TIME = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    // fixed bytes of the frames
    localparam logic [7:0] ADDR_BYTE  = 8'hC0;
    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_DISP   = 8'h8F;

    // seconds saturation and reciprocal of 60 (x * 8739 >> 19 == x / 60 below 6000)
    localparam logic [12:0] SEC_MAX     = 13'd5999;
    localparam logic [13:0] MIN_RECIP   = 14'd8739;
    localparam int          RECIP_SHIFT = 19;

    // one frame descriptor handed from front to back
    typedef struct packed {
        logic            kind;
        logic [3:0][7:0] data;   // digit bytes, sent index 0 first
    } t_frame;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // seven-segment pattern of a decimal digit
    function automatic logic [6:0] seg_encode(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0:    seg = 7'b0111111;
            4'd1:    seg = 7'b0110000;
            4'd2:    seg = 7'b1011011;
            4'd3:    seg = 7'b1111001;
            4'd4:    seg = 7'b1110100;
            4'd5:    seg = 7'b1101101;
            4'd6:    seg = 7'b1101111;
            4'd7:    seg = 7'b0111000;
            4'd8:    seg = 7'b1111111;
            4'd9:    seg = 7'b1111101;
            default: seg = 7'b0000000;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ----- design/mmss_seven_segment_serial_frame_core.sv -----
// ----------------------------------------------------------------------------
// mmss_seven_segment_serial_frame_core
// Two-wire display frame generator for a four-digit mm:ss LED display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one request per beat. i_kind = 0 shows
//   i_seconds as mm:ss (saturated at 99:59); i_kind = 1 sends the data and
//   display-control command frames.
//   Output channel (o_valid / i_stall): one serial symbol per beat, o_last
//   marks the final symbol of a request.
//   A time request yields 47 symbols, an init request 22. The serialiser
//   issues one symbol per cycle while i_stall is low, so the symbol
//   sequencer in the back end sets the request rate. After the request
//   beat the first symbol passes two further digit-split stages, queue
//   write, sequencer load and the output register.
//   Requests are taken while a frame is still going out, up to the front
//   stages plus queue depth, then o_stall rises.
//   When i_stall is high on a valid beat, the output beat holds and the sequencer pauses.
//   Synchronous reset empties the stages, queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mmss_seven_segment_serial_frame_core_assert.svh"

module mmss_seven_segment_serial_frame_core
    import mmss_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [13:0] i_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_symbol,
    output logic             o_bit_value,
    output logic             o_last
);

    t_frame    q_in_frame, q_out_frame;
    t_q_status q_status;
    logic      q_push, q_pop;

    // front: accept and digit split
    mmss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_seconds  (i_seconds),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_frame    (q_in_frame)
    );

    // descriptor queue
    mmss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_frame  (q_in_frame),
        .i_pop    (q_pop),
        .o_frame  (q_out_frame),
        .o_status (q_status)
    );

    // back: symbol serialiser
    mmss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (q_out_frame),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_bit_value (o_bit_value),
        .o_last      (o_last)
    );

    // checks
    `MMSS_ASSERT(a_last_on_stop, i_clk, i_rst_n, (o_valid && o_last) |-> (o_symbol == SYM_STOP))
    `MMSS_ASSERT(a_level_bit_only, i_clk, i_rst_n, (o_valid && (o_symbol != SYM_BIT)) |-> !o_bit_value)
    `MMSS_ASSERT(a_pop_not_empty, i_clk, i_rst_n, q_pop |-> !q_status.empty)
    `MMSS_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push && !q_pop, !q_status.empty)

endmodule

`default_nettype wire

// ----- design/mmss_front.sv -----
// ----------------------------------------------------------------------------
// mmss_front
// Accepts requests, saturates and splits the seconds count into digits and
// builds the segment bytes of a frame descriptor over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mmss_front
    import mmss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [13:0] i_seconds,
    input  wire t_q_status   i_q_status,
    output logic             o_push,
    output t_frame           o_frame
);

    // split a value below 100 into tens and units
    function automatic logic [7:0] split10(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(x) * 15'd205;
        tens  = prod[14:11];
        units = x - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

    logic        r_a_valid, r_b_valid, r_c_valid;
    logic        r_a_kind, r_b_kind;
    logic [12:0] r_a_sec;
    logic [6:0]  r_a_min, r_b_min;
    logic [5:0]  r_b_sec;
    t_frame      r_c_frame;

    logic        a_ready, b_ready, c_ready;
    logic [12:0] sec_sat;
    logic [25:0] min_prod;
    logic [12:0] sec_rem;
    logic [7:0]  sec_split, min_split;
    t_frame      n_frame;

    // stage flow control
    assign c_ready = !r_c_valid || !i_q_status.full;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_stall = !a_ready;
    assign o_push  = r_c_valid && !i_q_status.full;
    assign o_frame = r_c_frame;

    // stage A: saturate, minutes by reciprocal
    assign sec_sat  = (i_seconds > 14'(SEC_MAX)) ? SEC_MAX : i_seconds[12:0];
    assign min_prod = 26'(sec_sat) * 26'(MIN_RECIP);

    // stage B: remainder seconds
    assign sec_rem = r_a_sec - (13'({r_a_min, 6'b0}) - 13'({r_a_min, 2'b0}));

    // stage C: digits and segment bytes
    assign sec_split = split10({1'b0, r_b_sec});
    assign min_split = split10(r_b_min);

    always_comb begin
        n_frame.kind    = r_b_kind;
        n_frame.data[0] = {1'b0, seg_encode(sec_split[3:0])};
        n_frame.data[1] = {1'b1, seg_encode(sec_split[7:4])};   // colon
        n_frame.data[2] = {1'b0, seg_encode(min_split[3:0])};
        n_frame.data[3] = {1'b0, seg_encode(min_split[7:4])};
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_kind <= i_kind;
            r_a_sec  <= sec_sat;
            r_a_min  <= min_prod[RECIP_SHIFT +: 7];
        end
        if (b_ready && r_a_valid) begin
            r_b_kind <= r_a_kind;
            r_b_sec  <= sec_rem[5:0];
            r_b_min  <= r_a_min;
        end
        if (c_ready && r_b_valid) begin
            r_c_frame <= n_frame;
        end
    end

endmodule

`default_nettype wire

// ----- design/mmss_queue.sv -----
// ----------------------------------------------------------------------------
// mmss_queue
// Small descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mmss_queue
    import mmss_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_frame,
    input  wire logic   i_pop,
    output t_frame      o_frame,
    output t_q_status   o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_frame        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

`default_nettype wire

// ----- design/mmss_back.sv -----
// ----------------------------------------------------------------------------
// mmss_back
// Serialises frame descriptors into start, bit slot and stop symbols, one
// per cycle unless the output beat is stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mmss_back
    import mmss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_frame    i_frame,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_stall,
    output logic [1:0]     o_symbol,
    output logic           o_bit_value,
    output logic           o_last
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_BITS  = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    logic            r_busy;
    logic            r_kind;
    logic [3:0][7:0] r_data;
    logic [1:0]      r_phase;
    logic [2:0]      r_byte;
    logic [3:0]      r_bit;
    logic            r_o_valid;
    logic [1:0]      r_o_symbol;
    logic            r_o_bit;
    logic            r_o_last;

    logic            out_ready, emit, load;
    logic [7:0]      cur_byte;
    logic [1:0]      sym;
    logic            sym_bit, sym_last;
    logic [1:0]      n_phase;
    logic [2:0]      n_byte;
    logic [3:0]      n_bit;

    assign out_ready = !r_o_valid || !i_stall;
    assign emit      = r_busy && out_ready;
    assign sym_last  = (r_phase == PH_STOP) && ((r_kind == KIND_TIME) || (r_byte == 3'd1));
    assign load      = !r_busy || (emit && sym_last);
    assign o_pop     = load && !i_q_status.empty;

    // byte under transmission
    always_comb begin
        if (r_kind == KIND_INIT) begin
            cur_byte = (r_byte == 3'd0) ? CMD_DATA : CMD_DISP;
        end else begin
            case (r_byte)
                3'd0:    cur_byte = ADDR_BYTE;
                3'd1:    cur_byte = r_data[0];
                3'd2:    cur_byte = r_data[1];
                3'd3:    cur_byte = r_data[2];
                default: cur_byte = r_data[3];
            endcase
        end
    end

    // current symbol; ninth slot of a byte is the low acknowledge
    always_comb begin
        unique case (r_phase)
            PH_START: sym = SYM_START;
            PH_BITS:  sym = SYM_BIT;
            default:  sym = SYM_STOP;
        endcase
        sym_bit = (r_phase == PH_BITS) && (r_bit != 4'd8) && cur_byte[r_bit[2:0]];
    end

    // sequencer next state
    always_comb begin
        n_phase = r_phase;
        n_byte  = r_byte;
        n_bit   = r_bit;
        unique case (r_phase)
            PH_START: begin
                n_phase = PH_BITS;
                n_bit   = 4'd0;
            end
            PH_BITS: begin
                if (r_bit != 4'd8) begin
                    n_bit = r_bit + 4'd1;
                end else begin
                    n_bit = 4'd0;
                    if (r_kind == KIND_INIT || r_byte == 3'd4) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_byte = r_byte + 3'd1;
                    end
                end
            end
            default: begin
                // stop of the first command frame: open the second
                n_phase = PH_START;
                n_byte  = 3'd1;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_phase   <= PH_START;
            r_byte    <= 3'd0;
            r_bit     <= 4'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy  <= !i_q_status.empty;
                r_phase <= PH_START;
                r_byte  <= 3'd0;
                r_bit   <= 4'd0;
            end else if (emit) begin
                r_phase <= n_phase;
                r_byte  <= n_byte;
                r_bit   <= n_bit;
            end
            if (out_ready) begin
                r_o_valid <= emit;
            end
        end
    end

    // descriptor and output beat payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_frame.kind;
            r_data <= i_frame.data;
        end
        if (emit) begin
            r_o_symbol <= sym;
            r_o_bit    <= sym_bit;
            r_o_last   <= sym_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_symbol    = r_o_symbol;
    assign o_bit_value = r_o_bit;
    assign o_last      = r_o_last;

endmodule

`default_nettype wire

// ----- tb/mmss_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmss_frame_checker
// Watches the request and symbol channels of the frame core. Every request
// beat is expanded into the serial symbols it should produce. Every symbol
// beat is compared with the oldest one still outstanding.
// ----------------------------------------------------------------------------

module mmss_frame_checker
    import mmss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic        i_req_kind,
    input  wire logic [13:0] i_req_seconds,
    // symbol channel
    input  wire logic        i_sym_valid,
    input  wire logic        i_sym_stall,
    input  wire logic [1:0]  i_symbol,
    input  wire logic        i_bit_value,
    input  wire logic        i_last,
    // status for the top
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0] symbol;
        logic       bit_value;
        logic       last;
    } t_symbol_beat;

    t_symbol_beat expected_symbols [$];

    // segment patterns, bit 0 = segment d
    logic [6:0] digit_segments [0:9];

    initial begin
        digit_segments[0] = 7'b0111111;
        digit_segments[1] = 7'b0110000;
        digit_segments[2] = 7'b1011011;
        digit_segments[3] = 7'b1111001;
        digit_segments[4] = 7'b1110100;
        digit_segments[5] = 7'b1101101;
        digit_segments[6] = 7'b1101111;
        digit_segments[7] = 7'b0111000;
        digit_segments[8] = 7'b1111111;
        digit_segments[9] = 7'b1111101;
    end

    task automatic add_symbol(input logic [1:0] sym, input logic level);
        t_symbol_beat beat;
        beat.symbol    = sym;
        beat.bit_value = level;
        beat.last      = 1'b0;
        expected_symbols.push_back(beat);
    endtask

    // eight bit slots, LSB first, then the acknowledge slot held low
    task automatic add_byte(input logic [7:0] value);
        for (int i = 0; i < 8; i++)
            add_symbol(SYM_BIT, value[i]);
        add_symbol(SYM_BIT, 1'b0);
    endtask

    task automatic predict_frame(input logic kind, input logic [13:0] seconds);
        logic [13:0]  clamped;
        int           mins;
        int           secs;
        t_symbol_beat tail;
        if (kind == KIND_INIT) begin
            add_symbol(SYM_START, 1'b0);
            add_byte(CMD_DATA);
            add_symbol(SYM_STOP, 1'b0);
            add_symbol(SYM_START, 1'b0);
            add_byte(CMD_DISP);
            add_symbol(SYM_STOP, 1'b0);
        end else begin
            // anything past 99:59 saturates
            clamped = (seconds > SEC_MAX) ? 14'(SEC_MAX) : seconds;
            mins    = int'(clamped) / 60;
            secs    = int'(clamped) % 60;
            add_symbol(SYM_START, 1'b0);
            add_byte(ADDR_BYTE);
            add_byte({1'b0, digit_segments[secs % 10]});
            add_byte({1'b1, digit_segments[secs / 10]});   // colon on this byte
            add_byte({1'b0, digit_segments[mins % 10]});
            add_byte({1'b0, digit_segments[mins / 10]});
            add_symbol(SYM_STOP, 1'b0);
        end
        tail      = expected_symbols.pop_back();
        tail.last = 1'b1;
        expected_symbols.push_back(tail);
    endtask

    // compare symbol beats, then queue up the frame of a new request beat
    always @(posedge i_clk) begin
        t_symbol_beat want;
        t_symbol_beat got;
        if (!i_rst_n) begin
            expected_symbols.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_sym_valid && !i_sym_stall) begin
                got = '{symbol: i_symbol, bit_value: i_bit_value, last: i_last};
                if (expected_symbols.size() == 0) begin
                    $display("%0t: unexpected symbol beat sym=%0d bit=%0d last=%0d",
                             $time, got.symbol, got.bit_value, got.last);
                    o_errors++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (got !== want) begin
                        $display("%0t: symbol mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.symbol, want.bit_value, want.last,
                                 got.symbol, got.bit_value, got.last);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                predict_frame(i_req_kind, i_req_seconds);
            o_pending = expected_symbols.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the seven-segment serial frame core. Sends directed and
// random time and init requests with random gaps and output back-pressure,
// including one long hold-off that fills the core. The checker module
// predicts and compares the symbols; this top only reports the verdict.
// ----------------------------------------------------------------------------

module testbench;
    import mmss_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int PRESSURE_ITEMS = 12;
    localparam int RANDOM_ITEMS   = 280;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        i_kind    = 1'b0;
    logic [13:0] i_seconds = '0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_symbol;
    logic        o_bit_value;
    logic        o_last;

    logic        hold_req  = 1'b0;
    int          errors;
    int          pending;

    // mm:ss cases: extremes, saturation, digit coverage, odd bit patterns
    int unsigned directed_secs [16] = '{
        0, 1, 59, 60, 599, 600, 3599, 3600,
        1234, 4567, 3018, 2345, 5999, 6000, 16383, 10923
    };

    always #5 i_clk = ~i_clk;

    mmss_seven_segment_serial_frame_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_seconds   (i_seconds),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_bit_value (o_bit_value),
        .o_last      (o_last)
    );

    mmss_frame_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_kind    (i_kind),
        .i_req_seconds (i_seconds),
        .i_sym_valid   (o_valid),
        .i_sym_stall   (i_stall),
        .i_symbol      (o_symbol),
        .i_bit_value   (o_bit_value),
        .i_last        (o_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // offer one request and hold it until the beat is taken
    task automatic send_request(input logic kind, input logic [13:0] secs);
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_seconds <= secs;
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender gap: mostly none or short, now and then long
    task automatic sender_gap();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 60)      n = 0;
        else if (sel < 90) n = $urandom_range(1, 4);
        else if (sel < 98) n = $urandom_range(5, 30);
        else               n = $urandom_range(60, 200);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drop valid and wait for every outstanding symbol
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [13:0] pick_seconds();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 14'($urandom_range(0, 5999));
        if (sel < 65) return 14'($urandom_range(6000, 16383));
        if (sel < 80) begin
            case ($urandom_range(0, 4))
                0:       return 14'd0;
                1:       return 14'd5999;
                2:       return 14'd6000;
                3:       return 14'd16383;
                default: return 14'(60 * $urandom_range(0, 99) + $urandom_range(0, 1));
            endcase
        end
        return 14'($urandom_range(0, 16383));
    endfunction

    // receiver pacing: one long hold-off on request, otherwise random bursts
    initial begin : rx_pacing
        bit hold_done;
        int sel;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                sel = $urandom_range(0, 19);
                if (sel < 6) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(5, 60)) @(posedge i_clk);
                end else if (sel == 19) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(5, 40)) begin
                        i_stall <= ($urandom_range(0, 3) == 0);
                        @(posedge i_clk);
                    end
                end
            end
        end
    end

    // ends the run if neither channel moves a beat for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic kind;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: init frames with both seconds extremes, then time cases
        send_request(KIND_INIT, 14'd0);
        sender_gap();
        send_request(KIND_INIT, 14'h3FFF);
        sender_gap();
        foreach (directed_secs[i]) begin
            send_request(KIND_TIME, 14'(directed_secs[i]));
            sender_gap();
        end
        send_request(KIND_TIME, 14'h1555);
        drain();

        // long receiver hold-off while requests keep coming back to back
        hold_req <= 1'b1;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            send_request(KIND_TIME, pick_seconds());

        // random requests, with one full drain halfway
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_INIT : KIND_TIME;
            send_request(kind, kind == KIND_INIT ? 14'($urandom_range(0, 16383))
                                                 : pick_seconds());
            if (i == RANDOM_ITEMS / 2)
                drain();
            else
                sender_gap();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- mmss_seven_segment_serial_frame_core.f -----
+incdir+design
design/mmss_pkg.sv
design/mmss_front.sv
design/mmss_queue.sv
design/mmss_back.sv
design/mmss_seven_segment_serial_frame_core.sv
tb/mmss_frame_checker.sv
tb/testbench.sv
